FILE: hdl/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg: session table with aging, shared types and constants
// Kinds, event codes, controller states and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none
package sta_pkg;
  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned KEY_BITS_DEF = 50;
  localparam int unsigned KEY_W        = 50;
  localparam int unsigned TMO_W        = 16;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned REASON_W     = 4;
  localparam int unsigned EVENT_W      = 3;
  localparam int unsigned COUNT_W      = 7;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd30;

  localparam logic [KIND_W-1:0] KindCreate = 3'd0;
  localparam logic [KIND_W-1:0] KindQuery  = 3'd1;
  localparam logic [KIND_W-1:0] KindRemove = 3'd2;
  localparam logic [KIND_W-1:0] KindTick   = 3'd3;
  localparam logic [KIND_W-1:0] KindSweep  = 3'd4;
  localparam logic [KIND_W-1:0] KindPop    = 3'd5;

  localparam logic [EVENT_W-1:0] EvNone    = 3'd0;
  localparam logic [EVENT_W-1:0] EvCreated = 3'd1;
  localparam logic [EVENT_W-1:0] EvRefresh = 3'd2;
  localparam logic [EVENT_W-1:0] EvRemoved = 3'd3;
  localparam logic [EVENT_W-1:0] EvTimeout = 3'd4;
  localparam logic [EVENT_W-1:0] EvOffload = 3'd5;
  localparam logic [EVENT_W-1:0] EvFull    = 3'd6;

  typedef enum logic [2:0] {
    StIdle, StScan, StWait, StAct, StEmit
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, clear scan
    logic scan_step; // advance slot pointer, take registered read
    logic act;       // perform the update chosen for the current item
    logic emit;      // load output register
    logic present;   // show a held sweep eviction
    logic seal;      // mark the held sweep eviction last and show it
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // pointer past the last slot
    logic hit;        // slot read this cycle matches the scan criterion
    logic is_scan;    // current item walks the table
    logic many;       // sweep: emit per hit and keep going
    logic any_emit;   // sweep already produced a result
  } stat_t;
endpackage
`default_nettype wire

FILE: hdl/sta_if.sv
// ----------------------------------------------------------------------------
// sta_in_if / sta_out_if: valid/ready channels of the session table
// Input carries one command item, output one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface sta_in_if;
  logic                          valid;
  logic                          ready;
  logic [sta_pkg::KIND_W-1:0]    kind;
  logic [sta_pkg::KEY_W-1:0]     subscriber_key;
  logic [sta_pkg::REASON_W-1:0]  reason_code;
  modport source (output valid, kind, subscriber_key, reason_code, input ready);
  modport sink   (input valid, kind, subscriber_key, reason_code, output ready);
endinterface

interface sta_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [sta_pkg::EVENT_W-1:0]   event_res;
  logic [sta_pkg::KEY_W-1:0]     key_out;
  logic [sta_pkg::REASON_W-1:0]  reason_out;
  logic [sta_pkg::COUNT_W-1:0]   entry_count;
  logic                          last;
  modport source (output valid, ok, event_res, key_out, reason_out, entry_count, last,
                  input ready);
  modport sink   (input valid, ok, event_res, key_out, reason_out, entry_count, last,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/session_table_with_aging.sv
// ----------------------------------------------------------------------------
// session_table_with_aging: subscriber session table with timeout ageing
// Create, query, remove, tick, sweep and pop on a table of slots.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_if     in   valid/ready    kind, subscriber_key, reason_code
//  out_if    out  valid/ready    ok, event_res, key_out, reason_out, entry_count, last
//  cfg       in   cfg_we_i       cfg_wdata_i (timeout_seconds)
//
// Tick and unused kinds go from the idle state straight to the act state, which loads the result.
// A lookup reads the slots in turn, each through a scan state and a wait state, ending
// early on a hit. Sweep walks all slots and is also held by output stalls.
// The single memory read port sets the walk rate. No clearing pass after reset.
// A stalled output holds the sequencer; a sweep eviction is shown once the next
// eviction or the end of the walk fixes its last flag.
`default_nettype none
module session_table_with_aging #(
  parameter int unsigned ENTRIES  = sta_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = sta_pkg::KEY_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [sta_pkg::TMO_W-1:0]  cfg_wdata_i,
  sta_in_if.sink                          in_if,
  sta_out_if.source                       out_if
);
  sta_pkg::cmd_t  cmd;
  sta_pkg::stat_t stat;
  logic           out_busy;
  logic [KEY_BITS-1:0] key_ext;

  assign key_ext = KEY_BITS'(in_if.subscriber_key);

  sta_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sta_dpath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .kind_i     (in_if.kind),
    .key_i      (key_ext),
    .reason_i   (in_if.reason_code),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_busy_o (out_busy),
    .out_if     (out_if)
  );
endmodule
`default_nettype wire

FILE: hdl/sta_ctrl.sv
// ----------------------------------------------------------------------------
// sta_ctrl: sequencer of the session table
// Walks the slot memory one entry at a time, through a scan and a wait state, and steps results to the output.
// ----------------------------------------------------------------------------
`default_nettype none
module sta_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           out_busy_i,
  input  wire sta_pkg::stat_t stat_i,
  output sta_pkg::cmd_t       cmd_o
);
  sta_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sta_pkg::StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sta_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.is_scan ? sta_pkg::StScan : sta_pkg::StAct;
        end
      end
      sta_pkg::StScan: begin
        // issue read of current slot
        if (stat_i.scan_done) state_d = sta_pkg::StAct;
        else begin
          cmd_o.scan_step = 1'b1;
          state_d = sta_pkg::StWait;
        end
      end
      sta_pkg::StWait: begin
        // registered read data valid now
        if (stat_i.hit && stat_i.many) begin
          if (out_busy_i) cmd_o.present = 1'b1;
          else begin
            cmd_o.act  = 1'b1;
            cmd_o.emit = 1'b1;
            state_d    = sta_pkg::StScan;
          end
        end else if (stat_i.hit) state_d = sta_pkg::StAct;
        else state_d = sta_pkg::StScan;
      end
      sta_pkg::StAct: begin
        if (stat_i.many && stat_i.any_emit) begin
          cmd_o.seal = 1'b1;
          state_d    = sta_pkg::StIdle;
        end else if (!out_busy_i) begin
          cmd_o.act  = 1'b1;
          cmd_o.emit = 1'b1;
          state_d    = sta_pkg::StIdle;
        end
      end
      default: state_d = sta_pkg::StIdle;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/sta_dpath.sv
// ----------------------------------------------------------------------------
// sta_dpath: slot memory, occupancy bits, tick counter and result register
// Hit logic for lookup, free search, sweep ageing and pop.
// ----------------------------------------------------------------------------
`default_nettype none
module sta_dpath #(
  parameter int unsigned ENTRIES  = sta_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = sta_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sta_pkg::TMO_W-1:0]     cfg_wdata_i,
  input  wire logic [sta_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [KEY_BITS-1:0]           key_i,
  input  wire logic [sta_pkg::REASON_W-1:0]  reason_i,
  input  wire sta_pkg::cmd_t                 cmd_i,
  output sta_pkg::stat_t                     stat_o,
  output logic                               out_busy_o,
  sta_out_if.source                          out_if
);
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned PTR_W = IDX_W + 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0]              mem_key   [ENTRIES];
  logic [sta_pkg::TIME_W-1:0]       mem_start [ENTRIES];
  logic [ENTRIES-1:0]               valid_q;
  logic [KEY_BITS-1:0]              rd_key_q;
  logic [sta_pkg::TIME_W-1:0]       rd_start_q;
  logic                             rd_valid_q;
  logic [IDX_W-1:0]                 rd_idx_q;

  logic [sta_pkg::KIND_W-1:0]       kind_q;
  logic [KEY_BITS-1:0]              key_q;
  logic [sta_pkg::REASON_W-1:0]     reason_q;
  logic [PTR_W-1:0]                 ptr_q;
  logic                             found_q, free_q, any_q;
  logic [IDX_W-1:0]                 found_idx_q, free_idx_q;
  logic [sta_pkg::TIME_W-1:0]       now_q;
  logic [CNT_W-1:0]                 count_q, count_d;
  logic [sta_pkg::TMO_W-1:0]        tmo_q;

  logic                             ov_q, ok_q, last_q, hold_q;
  logic [sta_pkg::EVENT_W-1:0]      ev_q;
  logic [KEY_BITS-1:0]              ko_q;
  logic [sta_pkg::REASON_W-1:0]     ro_q;

  logic                             hit, aged, key_eq, wr_en;
  logic [IDX_W-1:0]                 wr_idx;
  logic                             ok_d, clr_en;
  logic [sta_pkg::EVENT_W-1:0]      ev_d;
  logic [KEY_BITS-1:0]              ko_d;
  logic [sta_pkg::REASON_W-1:0]     ro_d;
  logic [IDX_W-1:0]                 clr_idx;
  logic [sta_pkg::TIME_W-1:0]       age;

  assign key_eq = rd_valid_q && (rd_key_q == key_q);
  assign age    = now_q - rd_start_q;
  assign aged   = rd_valid_q && (age >= {{(sta_pkg::TIME_W-sta_pkg::TMO_W){1'b0}}, tmo_q});

  always_comb begin
    case (kind_q)
      sta_pkg::KindCreate, sta_pkg::KindQuery,
      sta_pkg::KindRemove: hit = key_eq;
      sta_pkg::KindSweep:  hit = aged;
      sta_pkg::KindPop:    hit = rd_valid_q;
      default:             hit = 1'b0;
    endcase
  end

  assign stat_o.hit       = hit;
  assign stat_o.scan_done = ptr_q[IDX_W] | ptr_q == PTR_W'(ENTRIES);
  assign stat_o.is_scan   = kind_i inside {sta_pkg::KindCreate, sta_pkg::KindQuery,
                                           sta_pkg::KindRemove, sta_pkg::KindSweep,
                                           sta_pkg::KindPop};
  assign stat_o.many      = (kind_q == sta_pkg::KindSweep);
  assign stat_o.any_emit  = any_q;
  assign out_busy_o       = ov_q && (hold_q || !out_if.ready);

  // result and table update selection
  always_comb begin
    ok_d = 1'b0; ev_d = sta_pkg::EvNone; ko_d = '0; ro_d = '0;
    wr_en = 1'b0; wr_idx = free_idx_q; clr_en = 1'b0; clr_idx = found_idx_q;
    count_d = count_q;
    case (kind_q)
      sta_pkg::KindCreate: begin
        ko_d = key_q;
        if (found_q) begin
          ev_d = sta_pkg::EvRefresh; wr_en = 1'b1; wr_idx = found_idx_q;
        end else if (free_q) begin
          ok_d = 1'b1; ev_d = sta_pkg::EvCreated; wr_en = 1'b1;
          count_d = count_q + CNT_W'(1);
        end else ev_d = sta_pkg::EvFull;
      end
      sta_pkg::KindQuery: begin
        ok_d = found_q; ko_d = key_q;
      end
      sta_pkg::KindRemove: begin
        ko_d = key_q;
        if (found_q) begin
          ok_d = 1'b1; ev_d = sta_pkg::EvRemoved; ro_d = reason_q; clr_en = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      sta_pkg::KindTick: ok_d = 1'b1;
      sta_pkg::KindSweep: begin
        ok_d = 1'b1;
        if (hit) begin
          ev_d = sta_pkg::EvTimeout; ko_d = rd_key_q;
          clr_en = 1'b1; clr_idx = rd_idx_q; count_d = count_q - CNT_W'(1);
        end
      end
      sta_pkg::KindPop: begin
        if (found_q) begin
          ok_d = 1'b1; ev_d = sta_pkg::EvOffload; ko_d = rd_key_q;
          clr_en = 1'b1; count_d = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act && wr_en) begin
      mem_start[wr_idx] <= now_q;
      if (!found_q) mem_key[wr_idx] <= key_q;
    end
    if (cmd_i.scan_step) begin
      rd_key_q   <= mem_key[ptr_q[IDX_W-1:0]];
      rd_start_q <= mem_start[ptr_q[IDX_W-1:0]];
      rd_idx_q   <= ptr_q[IDX_W-1:0];
    end
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      key_q    <= key_i;
      reason_q <= reason_i;
    end
    if (cmd_i.emit) begin
      ok_q <= ok_d; ev_q <= ev_d; ko_q <= ko_d; ro_q <= ro_d;
      last_q <= !(stat_o.many && hit);
    end
    if (cmd_i.seal) last_q <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; rd_valid_q <= 1'b0; ptr_q <= '0;
      found_q <= 1'b0; free_q <= 1'b0; any_q <= 1'b0;
      found_idx_q <= '0; free_idx_q <= '0;
      now_q <= '0; count_q <= '0; tmo_q <= sta_pkg::TMO_RESET; ov_q <= 1'b0;
      hold_q <= 1'b0;
    end else begin
      if (cfg_we_i) tmo_q <= cfg_wdata_i;
      if (ov_q && !hold_q && out_if.ready) ov_q <= 1'b0;
      if (cmd_i.emit) begin
        ov_q   <= 1'b1;
        hold_q <= stat_o.many && hit;
      end
      if (cmd_i.present || cmd_i.seal) hold_q <= 1'b0;
      if (cmd_i.load) begin
        ptr_q <= '0; found_q <= 1'b0; free_q <= 1'b0; any_q <= 1'b0;
        rd_valid_q <= 1'b0;
        if (kind_i == sta_pkg::KindTick) now_q <= now_q + sta_pkg::TIME_W'(1);
      end
      if (cmd_i.scan_step) begin
        rd_valid_q <= valid_q[ptr_q[IDX_W-1:0]];
        ptr_q      <= ptr_q + PTR_W'(1);
        if (!valid_q[ptr_q[IDX_W-1:0]] && !free_q) begin
          free_q <= 1'b1; free_idx_q <= ptr_q[IDX_W-1:0];
        end
      end
      // a single-result scan stops at its hit
      if (hit && !stat_o.many && !found_q) begin
        found_q <= 1'b1; found_idx_q <= rd_idx_q; ptr_q <= PTR_W'(ENTRIES);
        rd_valid_q <= 1'b0;
      end
      if (cmd_i.scan_step == 1'b0 && stat_o.many && hit && cmd_i.act)
        rd_valid_q <= 1'b0;
      if (cmd_i.act) begin
        count_q <= count_d;
        if (wr_en && !found_q) valid_q[wr_idx] <= 1'b1;
        if (clr_en) valid_q[clr_idx] <= 1'b0;
        if (stat_o.many) any_q <= 1'b1;
      end
    end
  end

  // hold a sweep eviction until the next one or the end of the walk fixes its last flag
  assign out_if.valid       = ov_q & ~hold_q;
  assign out_if.ok          = ok_q;
  assign out_if.event_res   = ev_q;
  assign out_if.key_out     = ko_q[sta_pkg::KEY_W-1:0];
  assign out_if.reason_out  = ro_q;
  assign out_if.entry_count = sta_pkg::COUNT_W'(count_q);
  assign out_if.last        = last_q;
endmodule
`default_nettype wire

FILE: hdl/sta_checker.sv
// ----------------------------------------------------------------------------
// sta_checker: port-level checks for the session table
// Output handshake and result sanity.
// ----------------------------------------------------------------------------
`default_nettype none
module sta_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       ov,
  input wire logic       ordy,
  input wire logic [2:0] ev,
  input wire logic       ok,
  input wire logic [6:0] cnt
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov && !ordy |=> ov) else $error("output dropped while stalled");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= 7'd64) else $error("count beyond table size");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov && ev == sta_pkg::EvFull |-> !ok) else $error("full flagged ok");
endmodule

bind session_table_with_aging sta_checker u_chk (
  .clk_i, .rst_ni, .ov(out_if.valid), .ordy(out_if.ready),
  .ev(out_if.event_res), .ok(out_if.ok), .cnt(out_if.entry_count)
);
`default_nettype wire
